### sv/assert_macros.svh
// Assertion macros shared by the ray/box classifier RTL.
// Included by files that carry concurrent checks; empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rbp check failed");
`define RBP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("rbp check failed");
`else
`define RBP_ASSERT(lbl, clk, rstn, prop)
`define RBP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/rbp_pkg.sv
// Types, constants and helpers for the ray/box point classifier.
// Used by every module of the block.
package rbp_pkg;

    localparam int COORD_W        = 20;
    localparam int IDX_W          = 20;
    localparam int CNT_W          = 21;
    localparam int DOT_W          = 42;
    localparam int CFG_W          = 60;
    localparam int U_W            = 64;
    localparam int U_FRAC         = 16;
    localparam int EPS_INV        = 1000;
    localparam int SQ_W           = 41;
    localparam int MAX_POINTS_DEF = 1048576;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [U_W-1:0]     uval_t;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_OCCL   = 2'd1,
        CLS_INSIDE = 2'd2,
        CLS_BEYOND = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        REG_ORIGIN = 3'd0,
        REG_AXIS_X = 3'd1,
        REG_AXIS_Y = 3'd2,
        REG_AXIS_Z = 3'd3,
        REG_HALF   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
        logic [2:0]       par;
        dot_t [2:0]       d;
        dot_t [2:0]       a;
        coord_t [2:0]     s;
    } job_t;

    function automatic coord_t part20(input logic [CFG_W-1:0] r, input int k);
        return coord_t'(r[COORD_W*k +: COORD_W]);
    endfunction

endpackage

### sv/rbp_front.sv
// Front end: takes a point, forms the dot products and |p|^2 on one shared
// multiplier, takes the integer square root and flags near-parallel axes. Uses rbp_pkg.
module rbp_front #(
    parameter int FRAC_BITS = rbp_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rbp_pkg::coord_t [2:0]       in_p,
    input  logic                        in_pvalid,
    input  logic [rbp_pkg::IDX_W-1:0]   in_index,
    input  logic                        in_last,
    input  logic [rbp_pkg::CFG_W-1:0]   cfg_origin,
    input  logic [rbp_pkg::CFG_W-1:0]   cfg_axis_x,
    input  logic [rbp_pkg::CFG_W-1:0]   cfg_axis_y,
    input  logic [rbp_pkg::CFG_W-1:0]   cfg_axis_z,
    input  logic [rbp_pkg::CFG_W-1:0]   cfg_half,
    output logic                        push,
    output rbp_pkg::job_t               push_job,
    input  logic                        full
);
    import rbp_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MAC  = 4'b0010,
        F_SQRT = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t          state_reg;
    coord_t [2:0]     p_reg;
    logic             pval_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             last_reg;
    logic [2:0]       grp_reg;
    logic [1:0]       term_reg;
    dot_t             acc_reg;
    dot_t             dst_reg [0:6];
    logic [SQ_W-1:0]  v_reg;
    logic [SQ_W:0]    res_reg;
    logic [SQ_W-1:0]  bit_reg;

    logic [CFG_W-1:0]   axis_sel;
    coord_t             opa;
    coord_t             opb;
    logic signed [39:0] prod;
    dot_t               sum;
    logic [SQ_W:0]      trial;
    logic [U_W-1:0]     thr;
    logic [U_W-1:0]     magd;
    dot_t               dcur;

    always_comb begin
        case (grp_reg)
            3'd0, 3'd3: axis_sel = cfg_axis_x;
            3'd1, 3'd4: axis_sel = cfg_axis_y;
            3'd2, 3'd5: axis_sel = cfg_axis_z;
            default:    axis_sel = '0;
        endcase
        opa  = (grp_reg >= 3'd3 && grp_reg <= 3'd5) ? part20(cfg_origin, int'(term_reg))
                                                     : p_reg[term_reg];
        opb  = (grp_reg == 3'd6) ? p_reg[term_reg] : part20(axis_sel, int'(term_reg));
        prod = opa * opb;
        sum  = acc_reg + DOT_W'(prod);
        trial = res_reg + (SQ_W+1)'(bit_reg);
    end

    always_comb begin
        thr = U_W'(res_reg) << FRAC_BITS;
        push_job.valid = pval_reg;
        push_job.last  = last_reg;
        push_job.index = idx_reg;
        magd = '0;
        dcur = '0;
        for (int i = 0; i < 3; i++) begin
            dcur = dst_reg[i];
            magd = dcur[DOT_W-1] ? U_W'(-dcur) : U_W'(dcur);
            push_job.d[i]   = dcur;
            push_job.a[i]   = dst_reg[i+3];
            push_job.s[i]   = part20(cfg_half, i);
            push_job.par[i] = (dcur == '0) || (magd * U_W'(EPS_INV) < thr);
        end
    end

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (in_valid) begin
                        p_reg    <= in_p;
                        pval_reg <= in_pvalid;
                        idx_reg  <= in_index;
                        last_reg <= in_last;
                        grp_reg  <= '0;
                        term_reg <= '0;
                        acc_reg  <= '0;
                        state_reg <= in_pvalid ? F_MAC : F_PUSH;
                    end
                end
                F_MAC: begin
                    if (term_reg == 2'd2) begin
                        dst_reg[grp_reg] <= sum;
                        acc_reg  <= '0;
                        term_reg <= '0;
                        grp_reg  <= grp_reg + 3'd1;
                        if (grp_reg == 3'd6) begin
                            v_reg     <= sum[SQ_W-1:0];
                            res_reg   <= '0;
                            bit_reg   <= SQ_W'(1) << (SQ_W - 1);
                            state_reg <= F_SQRT;
                        end
                    end else begin
                        acc_reg  <= sum;
                        term_reg <= term_reg + 2'd1;
                    end
                end
                F_SQRT: begin
                    if ({1'b0, v_reg} >= trial) begin
                        v_reg   <= v_reg - trial[SQ_W-1:0];
                        res_reg <= (res_reg >> 1) + (SQ_W+1)'(bit_reg);
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == SQ_W'(1)) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

### sv/rbp_fifo.sv
// Short queue of jobs between front and back end.
// Uses rbp_pkg for the job type.
module rbp_fifo #(
    parameter int DEPTH = rbp_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rbp_pkg::job_t wr_data,
    output logic          full,
    input  logic          pop,
    output rbp_pkg::job_t rd_data,
    output logic          empty
);
    import rbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WD = $clog2(DEPTH + 1);

    job_t              mem [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [CNT_WD-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_WD'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CNT_WD'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CNT_WD'(1);
            end
        end
    end

endmodule

### sv/rbp_back.sv
// Back end: slab clipping with a bit-serial divider, parallel-axis checks
// with a shift-add multiplier, classification and running counts. Uses rbp_pkg.
module rbp_back #(
    parameter int FRAC_BITS  = rbp_pkg::FRAC_BITS_DEF,
    parameter int MAX_POINTS = rbp_pkg::MAX_POINTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      empty,
    output logic                      pop,
    input  rbp_pkg::job_t             job,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rbp_pkg::cls_t             out_cls,
    output logic [rbp_pkg::IDX_W-1:0] out_kept,
    output logic [rbp_pkg::CNT_W-1:0] out_hits,
    output logic [rbp_pkg::CNT_W-1:0] out_occl,
    output logic [rbp_pkg::CNT_W-1:0] out_inside,
    output logic                      out_last
);
    import rbp_pkg::*;

    localparam logic [CNT_W-1:0] CAP = (MAX_POINTS < (2**CNT_W - 1)) ?
                                       CNT_W'(MAX_POINTS) : {CNT_W{1'b1}};

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_AXIS = 7'b0000010,
        B_DIV  = 7'b0000100,
        B_CLIP = 7'b0001000,
        B_PCHK = 7'b0010000,
        B_MUL  = 7'b0100000,
        B_FIN  = 7'b1000000
    } bstate_t;

    bstate_t          state_reg;
    job_t             job_reg;
    logic [1:0]       ax_reg;
    logic             side_reg;
    uval_t            lo_reg;
    uval_t            u0_reg;
    uval_t            u1_reg;
    logic             found_reg;
    logic             fail_reg;
    logic [DOT_W-1:0] rem_reg;
    logic [U_W-1:0]   quo_reg;
    logic [U_W-1:0]   nmag_reg;
    logic [DOT_W-1:0] dmag_reg;
    logic             qneg_reg;
    logic [5:0]       cnt_reg;
    logic [U_W-1:0]   macc_reg;
    logic [U_W-1:0]   mcand_reg;
    logic [DOT_W-1:0] mplier_reg;
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] occl_reg;
    logic [CNT_W-1:0] ins_reg;
    logic             ov_reg;
    cls_t             cls_reg;
    logic [IDX_W-1:0] kept_reg;
    logic [CNT_W-1:0] ohits_reg;
    logic [CNT_W-1:0] oocc_reg;
    logic [CNT_W-1:0] oins_reg;
    logic             olast_reg;

    dot_t           dd;
    uval_t          a64;
    uval_t          s64;
    uval_t          es;
    uval_t          num;
    logic [DOT_W:0] trial;
    uval_t          q;
    uval_t          nu0;
    uval_t          nu1;
    logic [U_W-1:0] addend;
    uval_t          diff;
    uval_t          dmg;
    uval_t          lim;
    logic           hit;
    cls_t           cls;
    logic [CNT_W-1:0] nh;
    logic [CNT_W-1:0] no;
    logic [CNT_W-1:0] ni;
    logic           slot_free;

    always_comb begin
        dd  = $signed(job_reg.d[ax_reg]);
        a64 = U_W'($signed(job_reg.a[ax_reg]));
        s64 = U_W'($signed(job_reg.s[ax_reg])) <<< FRAC_BITS;
        es  = dd[DOT_W-1] ? -s64 : s64;
        num = (side_reg ? (a64 + es) : (a64 - es)) <<< U_FRAC;
        trial = {rem_reg, nmag_reg[U_W-1]};
        q   = qneg_reg ? -$signed(quo_reg) : $signed(quo_reg);
        nu0 = (lo_reg > u0_reg) ? lo_reg : u0_reg;
        nu1 = q;
        if (found_reg && u1_reg < q) begin
            nu1 = u1_reg;
        end
        addend = mplier_reg[0] ? mcand_reg : '0;
        diff = (a64 <<< U_FRAC) - $signed(macc_reg);
        dmg  = diff[U_W-1] ? -diff : diff;
        lim  = s64 <<< U_FRAC;
        hit  = job_reg.valid && found_reg && !fail_reg;
        if (!hit) begin
            cls = CLS_NONE;
        end else if (u0_reg >= (U_W'(1) <<< U_FRAC)) begin
            cls = CLS_OCCL;
        end else if (u1_reg >= (U_W'(1) <<< U_FRAC)) begin
            cls = CLS_INSIDE;
        end else begin
            cls = CLS_BEYOND;
        end
        nh = (hit && hits_reg < CAP) ? hits_reg + CNT_W'(1) : hits_reg;
        no = (cls == CLS_OCCL && occl_reg < CAP) ? occl_reg + CNT_W'(1) : occl_reg;
        ni = (cls == CLS_INSIDE && ins_reg < CAP) ? ins_reg + CNT_W'(1) : ins_reg;
        slot_free = !ov_reg || out_ready;
    end

    assign pop        = (state_reg == B_IDLE) && !empty;
    assign out_valid  = ov_reg;
    assign out_cls    = cls_reg;
    assign out_kept   = kept_reg;
    assign out_hits   = ohits_reg;
    assign out_occl   = oocc_reg;
    assign out_inside = oins_reg;
    assign out_last   = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
            hits_reg  <= '0;
            occl_reg  <= '0;
            ins_reg   <= '0;
        end else begin
            if (ov_reg && out_ready && state_reg != B_FIN) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!empty) begin
                        job_reg   <= job;
                        found_reg <= 1'b0;
                        fail_reg  <= 1'b0;
                        ax_reg    <= '0;
                        side_reg  <= 1'b0;
                        state_reg <= job.valid ? B_AXIS : B_FIN;
                    end
                end
                B_AXIS: begin
                    if (ax_reg == 2'd3 || fail_reg) begin
                        ax_reg    <= '0;
                        side_reg  <= 1'b0;
                        state_reg <= (found_reg && !fail_reg) ? B_PCHK : B_FIN;
                    end else if (job_reg.par[ax_reg]) begin
                        ax_reg <= ax_reg + 2'd1;
                    end else begin
                        nmag_reg  <= num[U_W-1] ? -num : num;
                        dmag_reg  <= dd[DOT_W-1] ? -dd : dd;
                        qneg_reg  <= num[U_W-1] ^ dd[DOT_W-1];
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (trial >= {1'b0, dmag_reg}) begin
                        rem_reg <= DOT_W'(trial - {1'b0, dmag_reg});
                        quo_reg <= {quo_reg[U_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[DOT_W-1:0];
                        quo_reg <= {quo_reg[U_W-2:0], 1'b0};
                    end
                    nmag_reg <= nmag_reg << 1;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= B_CLIP;
                    end
                end
                B_CLIP: begin
                    if (!side_reg) begin
                        lo_reg   <= q;
                        side_reg <= 1'b1;
                    end else begin
                        u0_reg    <= found_reg ? nu0 : lo_reg;
                        u1_reg    <= nu1;
                        found_reg <= 1'b1;
                        if (found_reg && ((lo_reg > u0_reg ? lo_reg : u0_reg) > nu1)) begin
                            fail_reg <= 1'b1;
                        end
                        side_reg <= 1'b0;
                        ax_reg   <= ax_reg + 2'd1;
                    end
                    state_reg <= B_AXIS;
                end
                B_PCHK: begin
                    if (ax_reg == 2'd3 || fail_reg) begin
                        state_reg <= B_FIN;
                    end else if (!job_reg.par[ax_reg]) begin
                        ax_reg <= ax_reg + 2'd1;
                    end else begin
                        mcand_reg  <= side_reg ? u1_reg : u0_reg;
                        mplier_reg <= dd;
                        macc_reg   <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= B_MUL;
                    end
                end
                B_MUL: begin
                    if (cnt_reg == 6'(DOT_W - 1)) begin
                        macc_reg <= macc_reg - addend;
                    end else begin
                        macc_reg <= macc_reg + addend;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DOT_W)) begin
                        if (dmg > lim) begin
                            fail_reg <= 1'b1;
                        end
                        if (side_reg) begin
                            ax_reg <= ax_reg + 2'd1;
                        end
                        side_reg  <= !side_reg;
                        state_reg <= B_PCHK;
                    end
                end
                B_FIN: begin
                    if (slot_free) begin
                        ov_reg    <= 1'b1;
                        cls_reg   <= cls;
                        kept_reg  <= (cls == CLS_INSIDE) ? job_reg.index : '0;
                        ohits_reg <= nh;
                        oocc_reg  <= no;
                        oins_reg  <= ni;
                        olast_reg <= job_reg.last;
                        hits_reg  <= job_reg.last ? '0 : nh;
                        occl_reg  <= job_reg.last ? '0 : no;
                        ins_reg   <= job_reg.last ? '0 : ni;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

### sv/ray_box_point_classifier_top.sv
// Ray/oriented-box point classifier: top level with configuration registers.
// Depends on rbp_pkg, rbp_front, rbp_fifo, rbp_back and assert_macros.svh.
//
// Each point casts a ray from the origin through itself; the ray is clipped by
// the box slabs and the point is reported as no hit, occluding, inside or
// beyond, with running counts that restart after a tlast point. The front end
// forms a valid point's products in 21 shared-multiplier steps and its square
// root in 21 steps, then hands the job off; the back end does two slab
// divisions per non-parallel axis on a 64-step divider and two checks per
// parallel axis on a shift-add multiplier. An invalid point skips the
// arithmetic in both ends. A two-deep queue lets the front end work on the
// next point while the back end is busy.
`include "assert_macros.svh"
module ray_box_point_classifier_top #(
    parameter int MAX_POINTS = rbp_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = rbp_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // point_x, point_y, point_z, point_index
    input  logic        s_tuser,  // point_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // kept_index, hit_count, occlude_count, inside_count, pad
    output logic [1:0]  m_tuser,  // point_class
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import rbp_pkg::*;

    logic [CFG_W-1:0] origin_reg;
    logic [CFG_W-1:0] axx_reg;
    logic [CFG_W-1:0] axy_reg;
    logic [CFG_W-1:0] axz_reg;
    logic [CFG_W-1:0] half_reg;

    logic             wr_en;
    reg_idx_t         ridx;
    coord_t [2:0]     in_p;
    logic             push;
    logic             pop;
    logic             fifo_full;
    logic             fifo_empty;
    job_t             push_job;
    job_t             pop_job;
    cls_t             cls;
    logic [IDX_W-1:0] kept;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] occl;
    logic [CNT_W-1:0] ins;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign ridx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
            axx_reg    <= '0;
            axy_reg    <= '0;
            axz_reg    <= '0;
            half_reg   <= '0;
        end else if (wr_en) begin
            case (ridx)
                REG_ORIGIN: origin_reg <= pwdata[CFG_W-1:0];
                REG_AXIS_X: axx_reg    <= pwdata[CFG_W-1:0];
                REG_AXIS_Y: axy_reg    <= pwdata[CFG_W-1:0];
                REG_AXIS_Z: axz_reg    <= pwdata[CFG_W-1:0];
                REG_HALF:   half_reg   <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_ORIGIN: prdata = 64'(origin_reg);
            REG_AXIS_X: prdata = 64'(axx_reg);
            REG_AXIS_Y: prdata = 64'(axy_reg);
            REG_AXIS_Z: prdata = 64'(axz_reg);
            REG_HALF:   prdata = 64'(half_reg);
            default:    prdata = '0;
        endcase
    end

    assign in_p[0] = coord_t'(s_tdata[19:0]);
    assign in_p[1] = coord_t'(s_tdata[39:20]);
    assign in_p[2] = coord_t'(s_tdata[59:40]);

    rbp_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_p       (in_p),
        .in_pvalid  (s_tuser),
        .in_index   (s_tdata[79:60]),
        .in_last    (s_tlast),
        .cfg_origin (origin_reg),
        .cfg_axis_x (axx_reg),
        .cfg_axis_y (axy_reg),
        .cfg_axis_z (axz_reg),
        .cfg_half   (half_reg),
        .push       (push),
        .push_job   (push_job),
        .full       (fifo_full)
    );

    rbp_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (push_job),
        .full    (fifo_full),
        .pop     (pop),
        .rd_data (pop_job),
        .empty   (fifo_empty)
    );

    rbp_back #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (fifo_empty),
        .pop        (pop),
        .job        (pop_job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cls    (cls),
        .out_kept   (kept),
        .out_hits   (hits),
        .out_occl   (occl),
        .out_inside (ins),
        .out_last   (m_tlast)
    );

    assign m_tuser = cls;
    assign m_tdata = {5'b0, ins, occl, hits, kept};

    `RBP_ASSERT(a_push_room, aclk, aresetn, push |-> !fifo_full)
    `RBP_ASSERT(a_pop_data, aclk, aresetn, pop |-> !fifo_empty)
    `RBP_ASSERT(a_kept_zero, aclk, aresetn, (m_tvalid && cls != CLS_INSIDE) |-> kept == '0)
    `RBP_ASSERT(a_counts_le, aclk, aresetn, m_tvalid |-> (occl <= hits && ins <= hits))

endmodule
